### rtl/ssp_pkg.sv
// ssp_pkg: types and constants shared by the sensor sentence parser
// no dependencies; imported by ssp_core, sensor_sentence_parser_unit and ssp_checker

package ssp_pkg;

    // frame buffer size; the body may use all but three bytes of it
    localparam int FRAME_BUF_LEN = 64;
    localparam logic [7:0] MAX_BODY_LEN = 8'(FRAME_BUF_LEN - 3);

    // characters that steer the parser
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // tag matching progress
    localparam logic [2:0] TAG_MATCHED  = 3'd4;
    localparam logic [2:0] TAG_MISMATCH = 3'd7;

    // token indexes
    localparam logic [2:0] FLD_TAG   = 3'd0;
    localparam logic [2:0] FLD_TEMP  = 3'd1;
    localparam logic [2:0] FLD_HUM   = 3'd2;
    localparam logic [2:0] FLD_IN1   = 3'd3;
    localparam logic [2:0] FLD_IN4   = 3'd6;
    localparam logic [2:0] FLD_LAST  = 3'd7;

    // accumulator cap in tenths and output saturation
    localparam logic [16:0] ACC_CAP   = 17'h10000;
    localparam logic [15:0] TENTHS_MAX = 16'hFFFF;

    // number scanner phases
    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_SIGN  = 7'b0000010,
        PH_INT   = 7'b0000100,
        PH_FRAC1 = 7'b0001000,
        PH_FRAC2 = 7'b0010000,
        PH_FRACX = 7'b0100000,
        PH_DONE  = 7'b1000000
    } t_phase;

    // one result of a closed frame
    typedef struct packed {
        logic        frame_ok;
        logic [15:0] temp_tenths;
        logic [15:0] hum_tenths;
        logic [3:0]  input_mask;
    } t_result;

    // expected tag character at a given match position
    function automatic logic [7:0] tag_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = 8'h44;
            2'd1:    ch = 8'h41;
            2'd2:    ch = 8'h54;
            default: ch = 8'h41;
        endcase
        return ch;
    endfunction

endpackage

### rtl/sensor_sentence_parser_unit.sv
// A '#' is held in the input register; its result then goes into the result register that drives the outputs.
// Throughput: one byte per cycle unless a stall holds it; input register, parser state, result register.
// A byte that closes a frame waits in the input register while an older result is untaken.
// Reset (i_rst_n low, synchronous) empties both registers and clears all parser state.
// sensor_sentence_parser_unit: top level, handshakes around ssp_core; depends on ssp_pkg

module sensor_sentence_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_frame_ok,
    output logic [15:0] o_temp_tenths,
    output logic [15:0] o_hum_tenths,
    output logic [3:0]  o_input_mask
);
    import ssp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       emit;
    logic       proc;
    t_result    res;

    // parser core
    ssp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (res)
    );

    // a byte moves on unless it makes a result with no room for it
    assign proc    = r_in_valid && (!emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_ok    = r_out.frame_ok;
    assign o_temp_tenths = r_out.temp_tenths;
    assign o_hum_tenths  = r_out.hum_tenths;
    assign o_input_mask  = r_out.input_mask;

endmodule

### rtl/ssp_core.sv
// ssp_core: parser state and per-byte update for the sensor sentence parser
// depends on ssp_pkg; one byte is applied per enabled cycle

module ssp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [7:0]     i_byte,
    output logic           o_emit,
    output ssp_pkg::t_result o_result
);
    import ssp_pkg::*;

    logic        r_inside, n_inside;
    logic [7:0]  r_len, n_len;
    logic [2:0]  r_field, n_field;
    logic        r_within, n_within;
    logic [2:0]  r_tag, n_tag;
    t_phase      r_phase, n_phase;
    logic [16:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_round, n_round;
    logic        r_nz, n_nz;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic [3:0]  r_mask, n_mask;

    // character classes
    logic       is_dig, is_sp, is_plus, is_minus;
    logic [3:0] dig;

    // token state as seen by the byte (fresh when a token starts)
    t_phase      e_phase;
    logic [16:0] e_acc;
    logic        e_neg, e_round, e_nz;
    logic [2:0]  e_tag;

    // token state after feeding the byte
    t_phase      f_phase;
    logic [16:0] f_acc;
    logic        f_neg, f_round, f_nz;
    logic [2:0]  f_tag;
    logic [20:0] acc_x10;
    logic [16:0] acc_add;

    // commit of the open token
    logic [17:0] dec_sum;
    logic [15:0] dec_val;
    logic [15:0] c_temp, c_hum;
    logic [3:0]  c_mask;
    logic [2:0]  c_field;
    logic [2:0]  in_idx;

    // frame close
    logic [2:0]  end_field;
    logic [15:0] end_temp, end_hum;
    logic [3:0]  end_mask;
    logic        frame_good;

    // classify the byte
    always_comb begin
        is_dig   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        is_sp    = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
        is_plus  = (i_byte == CH_PLUS);
        is_minus = (i_byte == CH_MINUS);
        dig      = i_byte[3:0];
    end

    // token scanner: tag match, decimal or integer
    always_comb begin
        e_phase = r_within ? r_phase : PH_START;
        e_acc   = r_within ? r_acc : '0;
        e_neg   = r_within ? r_neg : 1'b0;
        e_round = r_within ? r_round : 1'b0;
        e_nz    = r_within ? r_nz : 1'b0;
        e_tag   = (!r_within && (r_field == FLD_TAG)) ? 3'd0 : r_tag;

        f_phase = e_phase;
        f_acc   = e_acc;
        f_neg   = e_neg;
        f_round = e_round;
        f_nz    = e_nz;
        f_tag   = e_tag;

        // times ten plus digit times ten, by shifts and adds
        acc_x10 = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0}
                + {14'd0, dig, 3'b000} + {16'd0, dig, 1'b0};
        acc_add = e_acc + {13'd0, dig};

        if (r_field == FLD_TAG) begin
            // match the tag text
            if ((e_tag < TAG_MATCHED) && (i_byte == tag_char(e_tag[1:0]))) begin
                f_tag = e_tag + 3'd1;
            end else begin
                f_tag = TAG_MISMATCH;
            end
        end else if (r_field <= FLD_HUM) begin
            // signed decimal in tenths
            case (e_phase)
                PH_START, PH_SIGN, PH_INT: begin
                    if ((e_phase == PH_START) && is_sp) begin
                        f_phase = PH_START;
                    end else if ((e_phase == PH_START) && (is_plus || is_minus)) begin
                        f_phase = PH_SIGN;
                        f_neg   = e_neg | is_minus;
                    end else if (is_dig) begin
                        f_acc   = (acc_x10 > {4'd0, ACC_CAP}) ? ACC_CAP : acc_x10[16:0];
                        f_phase = PH_INT;
                    end else if (i_byte == CH_DOT) begin
                        f_phase = PH_FRAC1;
                    end else begin
                        f_phase = PH_DONE;
                    end
                end
                PH_FRAC1: begin
                    if (is_dig) begin
                        f_acc   = acc_add;
                        f_phase = PH_FRAC2;
                    end else begin
                        f_phase = PH_DONE;
                    end
                end
                PH_FRAC2: begin
                    if (is_dig) begin
                        f_round = (dig >= 4'd5);
                        f_phase = PH_FRACX;
                    end else begin
                        f_phase = PH_DONE;
                    end
                end
                PH_FRACX: begin
                    if (!is_dig) begin
                        f_phase = PH_DONE;
                    end
                end
                default: begin
                    f_phase = e_phase;
                end
            endcase
        end else if (r_field <= FLD_IN4) begin
            // integer: only whether a nonzero digit shows up
            case (e_phase)
                PH_START, PH_SIGN, PH_INT: begin
                    if ((e_phase == PH_START) && is_sp) begin
                        f_phase = PH_START;
                    end else if ((e_phase == PH_START) && (is_plus || is_minus)) begin
                        f_phase = PH_SIGN;
                    end else if (is_dig) begin
                        f_nz    = e_nz | (i_byte != CH_ZERO);
                        f_phase = PH_INT;
                    end else begin
                        f_phase = PH_DONE;
                    end
                end
                default: begin
                    f_phase = e_phase;
                end
            endcase
        end
    end

    // token commit
    always_comb begin
        dec_sum = {1'b0, r_acc} + {17'd0, r_round};
        if (r_neg) begin
            dec_val = '0;
        end else if (dec_sum > {2'b00, TENTHS_MAX}) begin
            dec_val = TENTHS_MAX;
        end else begin
            dec_val = dec_sum[15:0];
        end

        in_idx = r_field - FLD_IN1;
        c_temp = (r_field == FLD_TEMP) ? dec_val : r_temp;
        c_hum  = (r_field == FLD_HUM) ? dec_val : r_hum;
        c_mask = r_mask;
        if ((r_field >= FLD_IN1) && (r_field <= FLD_IN4) && r_nz) begin
            c_mask[in_idx[1:0]] = 1'b1;
        end
        c_field = (r_field < FLD_LAST) ? (r_field + 3'd1) : r_field;
    end

    // frame close result
    always_comb begin
        end_field  = r_within ? c_field : r_field;
        end_temp   = r_within ? c_temp : r_temp;
        end_hum    = r_within ? c_hum : r_hum;
        end_mask   = r_within ? c_mask : r_mask;
        frame_good = (r_len != 8'd0) && (r_len <= MAX_BODY_LEN)
                   && (r_tag == TAG_MATCHED) && (end_field >= FLD_IN1);

        o_emit               = r_inside && (i_byte == CH_HASH);
        o_result.frame_ok    = frame_good;
        o_result.temp_tenths = frame_good ? end_temp : '0;
        o_result.hum_tenths  = frame_good ? end_hum : '0;
        o_result.input_mask  = frame_good ? end_mask : '0;
    end

    // next state per byte
    always_comb begin
        n_inside = r_inside;
        n_len    = r_len;
        n_field  = r_field;
        n_within = r_within;
        n_tag    = r_tag;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_round  = r_round;
        n_nz     = r_nz;
        n_temp   = r_temp;
        n_hum    = r_hum;
        n_mask   = r_mask;

        if (i_byte == CH_DOLLAR) begin
            // open or restart a frame
            n_inside = 1'b1;
            n_len    = '0;
            n_field  = FLD_TAG;
            n_within = 1'b0;
            n_tag    = '0;
            n_phase  = PH_START;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_round  = 1'b0;
            n_nz     = 1'b0;
            n_temp   = '0;
            n_hum    = '0;
            n_mask   = '0;
        end else if (r_inside) begin
            if (i_byte == CH_HASH) begin
                // close the frame
                n_inside = 1'b0;
                n_within = 1'b0;
                n_field  = end_field;
                n_temp   = end_temp;
                n_hum    = end_hum;
                n_mask   = end_mask;
            end else begin
                // body byte count, a zero byte spoils the frame
                if (i_byte == CH_NUL) begin
                    n_len = 8'hFF;
                end else if (r_len != 8'hFF) begin
                    n_len = r_len + 8'd1;
                end

                if (i_byte == CH_COMMA) begin
                    if (r_within) begin
                        n_within = 1'b0;
                        n_field  = c_field;
                        n_temp   = c_temp;
                        n_hum    = c_hum;
                        n_mask   = c_mask;
                    end
                end else begin
                    n_within = 1'b1;
                    n_tag    = f_tag;
                    n_phase  = f_phase;
                    n_acc    = f_acc;
                    n_neg    = f_neg;
                    n_round  = f_round;
                    n_nz     = f_nz;
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= '0;
            r_field  <= FLD_TAG;
            r_within <= 1'b0;
            r_tag    <= '0;
            r_phase  <= PH_START;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_round  <= 1'b0;
            r_nz     <= 1'b0;
            r_temp   <= '0;
            r_hum    <= '0;
            r_mask   <= '0;
        end else if (i_en) begin
            r_inside <= n_inside;
            r_len    <= n_len;
            r_field  <= n_field;
            r_within <= n_within;
            r_tag    <= n_tag;
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_round  <= n_round;
            r_nz     <= n_nz;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
            r_mask   <= n_mask;
        end
    end

endmodule

### rtl/ssp_checker.sv
// ssp_port_checker: port-level checks on sensor_sentence_parser_unit
// depends on ssp_pkg; attached to the top level by the bind at the end

module ssp_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_frame_ok,
    input logic [15:0] o_temp_tenths,
    input logic [15:0] o_hum_tenths,
    input logic [3:0]  o_input_mask
);
    import ssp_pkg::*;

    // nothing to show right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_frame_ok) && $stable(o_temp_tenths)
            && $stable(o_hum_tenths) && $stable(o_input_mask))
        else $error("result payload changed while stalled");

    // bad frames carry zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_ok |-> (o_temp_tenths == '0) && (o_hum_tenths == '0)
            && (o_input_mask == '0))
        else $error("bad frame with nonzero fields");

endmodule

bind sensor_sentence_parser_unit ssp_port_checker u_ssp_checker (.*);
